>>> sv/trcq_pkg.sv
package trcq_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int FRAC_BITS = 32;
   localparam int MAX_RELEASE = 64;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [31:0] SAMPLE_RATE_RESET = 32'd1000000;

   localparam logic [1:0] CMD_RETUNE = 2'd0;
   localparam logic [1:0] CMD_REFERENCE = 2'd1;
   localparam logic [1:0] CMD_BLOCK = 2'd2;

   localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] REG_ORIGIN_SECS = 2'd1;
   localparam logic [1:0] REG_ORIGIN_FRAC = 2'd2;

   localparam logic KIND_FREQ = 1'b0;
   localparam logic KIND_TAG = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic signed [47:0] freq_offset;
      logic has_time;
      logic [63:0] time_secs;
      logic [31:0] time_frac;
      logic [63:0] sample_pos;
      logic [15:0] block_len;
   } req_type;

   typedef struct packed {
      logic kind;
      logic [63:0] tag_sample;
      logic signed [47:0] freq_value;
      logic queue_full;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] freq;
      logic [63:0] target;
      logic now;
   } ent_type;

   localparam int ENT_W = $bits(ent_type);

endpackage

>>> sv/trcq_ram.sv
module trcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/timed_retune_command_queue.sv
// A timed retune command steps through MUL0, MUL1, MUL2 and FIN before EMIT gives its
// frequency transaction (three passes through one shared 32x32 multiplier, then a final add);
// an untimed one goes straight to EMIT. A sample block releases its tags one at a time via
// WAIT and TEST, paced by the memory's registered read of the head entry and held while the
// output stalls; the last tag is loaded once the stop test holds. Reset clears the pointers,
// the count and the reference; the queue memory keeps its contents and needs no clearing pass.
module timed_retune_command_queue #(
   parameter int QUEUE_DEPTH = trcq_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input trcq_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output trcq_pkg::rsp_type rsp_data,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [trcq_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [trcq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [trcq_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   import trcq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int REL_W = $clog2(MAX_RELEASE + 1);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL0 = 8'b0000_0010,
      ST_MUL1 = 8'b0000_0100,
      ST_MUL2 = 8'b0000_1000,
      ST_FIN  = 8'b0001_0000,
      ST_EMIT = 8'b0010_0000,
      ST_WAIT = 8'b0100_0000,
      ST_TEST = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] rate_ff, rate_in;
   logic [63:0] origin_secs_ff, origin_secs_in;
   logic [31:0] origin_frac_ff, origin_frac_in;
   logic [63:0] ref_secs_ff, ref_secs_in;
   logic [31:0] ref_frac_ff, ref_frac_in;
   logic [63:0] ref_sample_ff, ref_sample_in;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [REL_W-1:0] rel_ff, rel_in;

   logic [47:0] freq_ff, freq_in;
   logic now_ff, now_in;
   logic [63:0] dsec_ff, dsec_in;
   logic [31:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [63:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;

   logic pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic csr_wr;
   logic [1:0] csr_index;
   logic req_accept;
   logic out_free;
   logic out_load;
   rsp_type out_data;
   logic [31:0] mul_a;
   logic [63:0] mul_res;
   logic [63:0] frac_part;
   logic [47:0] freq_neg;
   logic q_full;
   logic mem_wr;
   ent_type mem_wdata;
   ent_type mem_rdata;
   logic [64:0] diff;
   logic late;
   logic in_block;
   logic due;
   logic stop;
   logic [63:0] tag_at;

   trcq_ram #(
      .WIDTH(ENT_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue_ram (
      .clock(clock),
      .wr_en(mem_wr),
      .wr_addr(tail_ff),
      .wr_data(mem_wdata),
      .rd_addr(head_ff),
      .rd_data(mem_rdata)
   );

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign csr_index = paddr[4:3];

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_SAMPLE_RATE: prdata = {32'b0, rate_ff};
         REG_ORIGIN_SECS: prdata = origin_secs_ff;
         REG_ORIGIN_FRAC: prdata = {32'b0, origin_frac_ff};
         default: prdata = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign freq_neg = (req_data.freq_offset == {1'b1, 47'b0}) ? {1'b0, {47{1'b1}}}
                                                             : 48'(-req_data.freq_offset);

   always_comb begin
      unique case (state_ff)
         ST_MUL0: mul_a = dsec_ff[31:0];
         ST_MUL1: mul_a = dsec_ff[63:32];
         default: mul_a = mag_ff;
      endcase
   end

   assign mul_res = 64'(mul_a) * 64'(rate_ff);
   assign frac_part = prod_ff >> FRAC_BITS;
   assign q_full = (count_ff == CNT_W'(QUEUE_DEPTH));

   assign diff = {1'b0, mem_rdata.target} - {1'b0, pos_ff};
   assign late = diff[64];
   assign in_block = (diff[63:16] == 48'b0) && (diff[15:0] < len_ff);
   assign due = mem_rdata.now || late || in_block;
   assign stop = (count_ff == '0) || (rel_ff == REL_W'(MAX_RELEASE)) || !due;
   assign tag_at = (mem_rdata.now || late) ? pos_ff : mem_rdata.target;

   assign mem_wdata.freq = freq_ff;
   assign mem_wdata.target = acc_ff;
   assign mem_wdata.now = now_ff;

   always_comb begin
      state_in = state_ff;
      rate_in = rate_ff;
      origin_secs_in = origin_secs_ff;
      origin_frac_in = origin_frac_ff;
      ref_secs_in = ref_secs_ff;
      ref_frac_in = ref_frac_ff;
      ref_sample_in = ref_sample_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      rel_in = rel_ff;
      freq_in = freq_ff;
      now_in = now_ff;
      dsec_in = dsec_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      out_load = 1'b0;
      out_data = pend_ff;
      mem_wr = 1'b0;

      if (csr_wr) begin
         unique case (csr_index)
            REG_SAMPLE_RATE: rate_in = pwdata[31:0];
            REG_ORIGIN_SECS: begin
               origin_secs_in = pwdata;
               ref_secs_in = pwdata;
            end
            REG_ORIGIN_FRAC: begin
               origin_frac_in = pwdata[31:0];
               ref_frac_in = pwdata[31:0];
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               freq_in = freq_neg;
               now_in = !req_data.has_time;
               dsec_in = req_data.time_secs - ref_secs_ff;
               neg_in = req_data.time_frac < ref_frac_ff;
               mag_in = (req_data.time_frac < ref_frac_ff) ? ref_frac_ff - req_data.time_frac
                                                           : req_data.time_frac - ref_frac_ff;
               pos_in = req_data.sample_pos;
               len_in = req_data.block_len;
               rel_in = '0;
               acc_in = '0;
               unique case (req_data.cmd)
                  CMD_RETUNE: state_in = req_data.has_time ? ST_MUL0 : ST_EMIT;
                  CMD_REFERENCE: begin
                     ref_secs_in = req_data.time_secs;
                     ref_frac_in = req_data.time_frac;
                     ref_sample_in = req_data.sample_pos;
                  end
                  CMD_BLOCK: state_in = (count_ff != '0) ? ST_WAIT : ST_IDLE;
                  default: ;
               endcase
            end
         end
         ST_MUL0: begin
            prod_in = mul_res;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in = prod_ff + ref_sample_ff;
            prod_in = mul_res;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in = acc_ff + {prod_ff[31:0], 32'b0};
            prod_in = mul_res;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            acc_in = neg_ff ? acc_ff - frac_part : acc_ff + frac_part;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data.kind = KIND_FREQ;
               out_data.tag_sample = acc_ff;
               out_data.freq_value = freq_ff;
               out_data.queue_full = q_full;
               out_data.last = 1'b1;
               if (!q_full) begin
                  mem_wr = 1'b1;
                  tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_WAIT: state_in = ST_TEST;
         ST_TEST: begin
            if (stop) begin
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  out_load = 1'b1;
                  out_data.last = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end else if (!pend_valid_ff || out_free) begin
               out_load = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_in.kind = KIND_TAG;
               pend_in.tag_sample = tag_at;
               pend_in.freq_value = mem_rdata.freq;
               pend_in.queue_full = 1'b0;
               pend_in.last = 1'b0;
               head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
               count_in = count_ff - CNT_W'(1);
               rel_in = rel_ff + REL_W'(1);
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      rsp_in = out_load ? out_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rate_ff <= SAMPLE_RATE_RESET;
         origin_secs_ff <= '0;
         origin_frac_ff <= '0;
         ref_secs_ff <= '0;
         ref_frac_ff <= '0;
         ref_sample_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         rel_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rate_ff <= rate_in;
         origin_secs_ff <= origin_secs_in;
         origin_frac_ff <= origin_frac_in;
         ref_secs_ff <= ref_secs_in;
         ref_frac_ff <= ref_frac_in;
         ref_sample_ff <= ref_sample_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         rel_ff <= rel_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      now_ff <= now_in;
      dsec_ff <= dsec_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      pos_ff <= pos_in;
      len_ff <= len_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

>>> bench/tb_timed_retune_command_queue.sv
module tb_timed_retune_command_queue;
   import trcq_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [47:0] FREQ_MIN = 48'h8000_0000_0000;
   localparam logic [47:0] FREQ_MAX = 48'h7FFF_FFFF_FFFF;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 600;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   ent_type cmd_fifo[$];
   rsp_type freq_tag_q[$];
   logic [31:0] rate_hz = SAMPLE_RATE_RESET;
   logic [63:0] anchor_secs = '0;
   logic [31:0] anchor_frac = '0;
   logic [63:0] anchor_sample = '0;

   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   logic hold_request = 1'b0;
   int hold_left = 0;
   stall_mode_type pat_mode = STALL_NONE;
   int pat_left = 0;
   rsp_type want;

   timed_retune_command_queue i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [47:0] negated_freq(input logic [47:0] v);
      if (v == FREQ_MIN) begin
         return FREQ_MAX;
      end
      return -v;
   endfunction

   function automatic logic [63:0] target_of(input logic [63:0] secs, input logic [31:0] frac);
      logic [63:0] whole;
      logic [63:0] prod;
      logic [63:0] part;
      logic [31:0] mag;
      logic behind;
      whole = (secs - anchor_secs) * {32'd0, rate_hz};
      behind = frac < anchor_frac;
      mag = behind ? anchor_frac - frac : frac - anchor_frac;
      prod = {32'd0, mag} * {32'd0, rate_hz};
      part = {32'd0, prod[63:32]};
      if (behind) begin
         part = -part;
      end
      return whole + part + anchor_sample;
   endfunction

   function automatic void update_retune_queue(input req_type item);
      ent_type ent;
      rsp_type res;
      logic [63:0] at;
      logic full;
      int released;
      case (item.cmd)
         CMD_RETUNE: begin
            ent.freq = negated_freq(item.freq_offset);
            ent.now = !item.has_time;
            ent.target = ent.now ? 64'd0 : target_of(item.time_secs, item.time_frac);
            full = cmd_fifo.size() >= QUEUE_DEPTH_DEF;
            if (!full) begin
               cmd_fifo.push_back(ent);
            end
            res.kind = KIND_FREQ;
            res.tag_sample = ent.target;
            res.freq_value = ent.freq;
            res.queue_full = full;
            res.last = 1'b1;
            freq_tag_q.push_back(res);
         end
         CMD_REFERENCE: begin
            anchor_secs = item.time_secs;
            anchor_frac = item.time_frac;
            anchor_sample = item.sample_pos;
         end
         CMD_BLOCK: begin
            released = 0;
            while (cmd_fifo.size() > 0 && released < MAX_RELEASE) begin
               ent = cmd_fifo[0];
               if (ent.now || ent.target < item.sample_pos) begin
                  at = item.sample_pos;
               end else if (ent.target - item.sample_pos < {48'd0, item.block_len}) begin
                  at = ent.target;
               end else begin
                  break;
               end
               res.kind = KIND_TAG;
               res.tag_sample = at;
               res.freq_value = ent.freq;
               res.queue_full = 1'b0;
               res.last = 1'b0;
               freq_tag_q.push_back(res);
               void'(cmd_fifo.pop_front());
               released++;
            end
            if (released > 0) begin
               freq_tag_q[freq_tag_q.size() - 1].last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic req_type scrambled_item();
      req_type item;
      item.cmd = 2'($urandom);
      item.freq_offset = 48'({$urandom, $urandom});
      item.has_time = 1'($urandom);
      item.time_secs = {$urandom, $urandom};
      item.time_frac = $urandom;
      item.sample_pos = {$urandom, $urandom};
      item.block_len = 16'($urandom);
      return item;
   endfunction

   function automatic req_type retune(input logic [47:0] freq, input logic timed,
                                      input logic [63:0] secs, input logic [31:0] frac);
      req_type item;
      item = scrambled_item();
      item.cmd = CMD_RETUNE;
      item.freq_offset = freq;
      item.has_time = timed;
      item.time_secs = secs;
      item.time_frac = frac;
      return item;
   endfunction

   function automatic req_type ref_time_item(input logic [63:0] secs, input logic [31:0] frac,
                                             input logic [63:0] pos);
      req_type item;
      item = scrambled_item();
      item.cmd = CMD_REFERENCE;
      item.time_secs = secs;
      item.time_frac = frac;
      item.sample_pos = pos;
      return item;
   endfunction

   function automatic req_type sample_block(input logic [63:0] pos, input logic [15:0] len);
      req_type item;
      item = scrambled_item();
      item.cmd = CMD_BLOCK;
      item.sample_pos = pos;
      item.block_len = len;
      return item;
   endfunction

   function automatic logic [47:0] random_freq();
      case ($urandom_range(0, 19))
         0: return FREQ_MIN;
         1: return FREQ_MAX;
         2: return 48'd0;
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [63:0] near_secs();
      if ($urandom_range(0, 19) == 0) begin
         return {$urandom, $urandom};
      end
      return anchor_secs + 64'($urandom_range(0, 3)) - 64'd1;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] expv,
                                input logic [63:0] got);
      if (got !== expv) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expv, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (freq_tag_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = freq_tag_q.pop_front();
            compare_field("kind", want.kind, rsp_data.kind);
            compare_field("tag_sample", want.tag_sample, rsp_data.tag_sample);
            compare_field("freq_value", want.freq_value, rsp_data.freq_value);
            compare_field("queue_full", want.queue_full, rsp_data.queue_full);
            compare_field("last", want.last, rsp_data.last);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (pat_left == 0) begin
            pat_mode = stall_mode_type'($urandom_range(0, 3));
            pat_left = $urandom_range(16, 80);
         end
         pat_left--;
         case (pat_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= (cycle_count % 3 == 0);
         endcase
      end
   end

   task automatic send_item(input req_type item);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_retune_queue(item);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (freq_tag_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_SAMPLE_RATE: rate_hz = value[31:0];
         REG_ORIGIN_SECS: anchor_secs = value;
         REG_ORIGIN_FRAC: anchor_frac = value[31:0];
         default: begin
         end
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic release_all();
      send_item(sample_block('1, 16'd1));
   endtask

   task automatic test_directed();
      req_type item;
      send_item(retune(48'd0, 1'b0, 64'd0, 32'd0));
      send_item(retune(FREQ_MAX, 1'b0, 64'd0, 32'd0));
      send_item(retune(FREQ_MIN, 1'b0, 64'd0, 32'd0));
      send_item(retune(48'hFFFF_FFFF_FFFF, 1'b0, 64'd0, 32'd0));
      send_item(retune(48'h0000_0001_8000, 1'b1, 64'd1, 32'd0));
      send_item(retune(48'h1234_5678_9ABC, 1'b1, 64'd0, 32'h8000_0000));
      send_item(ref_time_item(64'd10, 32'h8000_0000, 64'd5000));
      send_item(retune(48'hFEDC_BA98_7654, 1'b1, 64'd9, 32'd0));
      send_item(retune(48'h0000_0000_0001, 1'b1, 64'd10, 32'h4000_0000));
      send_item(sample_block(64'd0, 16'd0));
      send_item(sample_block(64'd950000, 16'hFFFF));
      item = scrambled_item();
      item.cmd = CMD_UNUSED;
      send_item(item);
      send_item(sample_block('1, 16'd1));
      send_item(sample_block('1, 16'hFFFF));
      send_item(retune(48'h0000_0002_0000, 1'b1, 64'd10, 32'h8000_0000));
      send_item(sample_block(64'd4000, 16'd1000));
      send_item(sample_block(64'd4000, 16'd1001));
   endtask

   task automatic test_config_extremes();
      settle();
      csr_write(REG_SAMPLE_RATE, 64'd0);
      send_item(retune(random_freq(), 1'b1, 64'd77, $urandom));
      send_item(retune(random_freq(), 1'b1, {$urandom, $urandom}, 32'hFFFF_FFFF));
      settle();
      csr_write(REG_ORIGIN_SECS, '1);
      csr_write(REG_ORIGIN_FRAC, 64'hFFFF_FFFF);
      csr_write(REG_SAMPLE_RATE, 64'hFFFF_FFFF);
      send_item(retune(random_freq(), 1'b1, 64'd0, 32'd0));
      send_item(retune(random_freq(), 1'b1, '1, 32'hFFFF_FFFF));
      send_item(retune(random_freq(), 1'b1, 64'd3, 32'd0));
      send_item(sample_block(anchor_sample, 16'hFFFF));
      release_all();
      settle();
      csr_write(REG_SAMPLE_RATE, 64'd1);
      csr_write(REG_ORIGIN_SECS, 64'd0);
      csr_write(REG_ORIGIN_FRAC, 64'd0);
      send_item(retune(random_freq(), 1'b1, 64'd5, 32'hFFFF_FFFF));
      release_all();
   endtask

   task automatic test_queue_full();
      settle();
      csr_write(REG_SAMPLE_RATE, 64'd48000);
      csr_write(REG_ORIGIN_SECS, {$urandom, $urandom});
      csr_write(REG_ORIGIN_FRAC, {32'd0, $urandom});
      release_all();
      repeat (QUEUE_DEPTH_DEF + 2) begin
         send_item(retune(random_freq(), 1'($urandom), near_secs(), $urandom));
      end
      release_all();
   endtask

   task automatic test_backpressure();
      release_all();
      hold_request = 1'b1;
      repeat (40) begin
         send_item(retune(random_freq(), 1'($urandom), near_secs(), $urandom));
      end
      release_all();
   endtask

   task automatic test_random_traffic(input logic [31:0] rate, input logic [63:0] secs,
                                      input logic [31:0] frac, input int count);
      req_type item;
      int sent;
      int pick;
      int reach;
      logic [15:0] len;
      logic [63:0] pos;
      settle();
      csr_write(REG_SAMPLE_RATE, {32'd0, rate});
      csr_write(REG_ORIGIN_SECS, secs);
      csr_write(REG_ORIGIN_FRAC, {32'd0, frac});
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            item = retune(random_freq(), $urandom_range(0, 4) != 0, near_secs(), $urandom);
         end else if (pick < 55) begin
            pos = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                              : anchor_sample + 64'($urandom);
            item = ref_time_item(near_secs(), $urandom, pos);
         end else if (pick < 95) begin
            case ($urandom_range(0, 9))
               0: len = 16'd0;
               1, 2: len = 16'($urandom);
               default: len = 16'($urandom_range(1, 4096));
            endcase
            reach = $urandom_range(0, int'(len) + 8);
            if (cmd_fifo.size() > 0 && $urandom_range(0, 9) < 7) begin
               pos = $urandom_range(0, 1) ? cmd_fifo[0].target - 64'(reach)
                                          : cmd_fifo[0].target + 64'(reach);
            end else if ($urandom_range(0, 1)) begin
               pos = anchor_sample + 64'($urandom) % (64'(rate_hz) * 64'd4 + 64'd1);
            end else begin
               pos = {$urandom, $urandom};
            end
            item = sample_block(pos, len);
         end else begin
            item = scrambled_item();
            item.cmd = CMD_UNUSED;
         end
         send_item(item);
         if (item.cmd != CMD_UNUSED) begin
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_queue_full();
      test_backpressure();
      test_random_traffic(32'd1000, 64'd0, 32'd0, 30);
      test_random_traffic(32'd48000, {$urandom, $urandom}, $urandom, 25);
      test_random_traffic(32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 25);
      test_random_traffic(32'd1, 64'd0, 32'd0, 20);
      test_random_traffic(SAMPLE_RATE_RESET, {$urandom, $urandom}, $urandom, 25);
      settle();
      if (error_count == 0 && freq_tag_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
sv/trcq_pkg.sv
sv/trcq_ram.sv
sv/timed_retune_command_queue.sv
bench/tb_timed_retune_command_queue.sv
